// ----- rtl/core/fnvxs_pkg.sv -----
package fnvxs_pkg;

  // item codes
  localparam logic [1:0] FUNC_START   = 2'd0;
  localparam logic [1:0] FUNC_LENGTH  = 2'd1;
  localparam logic [1:0] FUNC_BYTE    = 2'd2;
  localparam logic [1:0] FUNC_SQUEEZE = 2'd3;

  localparam logic [63:0] FNV_BASIS = 64'h14650FB0739D0383;
  localparam logic [63:0] FNV_PRIME = 64'h00000100000001B3;
  localparam logic [63:0] XS_MULT   = 64'h2545F4914F6CDD1D;

  localparam int unsigned XS_SHR_A = 12;
  localparam int unsigned XS_SHL   = 25;
  localparam int unsigned XS_SHR_B = 27;
  localparam int unsigned TOP_LSB  = 56;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] word;
    logic [7:0]  data_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic ld_start;   // hash <= basis ^ domain
    logic ld_mix;     // x <= hash ^ operand
    logic mix_byte;   // operand is the data byte, not the word
    logic ld_shift;   // x <= xorshift(hash)
    logic mul0;       // acc <= xL * cL
    logic mul1;       // acc.hi += xH * cL
    logic mul2;       // hash <= acc with hi += xL * cH
    logic sel_xs;     // multiplier constant: xorshift64* rather than FNV prime
    logic emit;       // load result register from hash
    logic last;
  } cmd_t;

endpackage

// ----- rtl/core/fnvxs_dpath.sv -----
module fnvxs_dpath (
  input  logic             clk,
  input  logic             rst,
  input  fnvxs_pkg::cmd_t  cmd,
  input  fnvxs_pkg::in_t   item,
  output fnvxs_pkg::out_t  result
);
  import fnvxs_pkg::*;

  logic [63:0] hash;
  logic [63:0] x;
  logic [63:0] acc;
  logic [63:0] mul_const;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [31:0] hi_sum;
  logic [63:0] operand;
  logic [63:0] shifted;

  function automatic logic [63:0] xorshift(input logic [63:0] v);
    logic [63:0] t;
    t = v ^ (v >> XS_SHR_A);
    t = t ^ (t << XS_SHL);
    t = t ^ (t >> XS_SHR_B);
    return t;
  endfunction

  assign operand   = cmd.mix_byte ? {56'd0, item.data_byte} : item.word;
  assign shifted   = xorshift(hash);
  assign mul_const = cmd.sel_xs ? XS_MULT : FNV_PRIME;

  // one shared 32x32 multiplier; the three partial products that land
  // below bit 64 are taken in turn under mul0, mul1 and mul2
  assign mul_a  = cmd.mul1 ? x[63:32] : x[31:0];
  assign mul_b  = cmd.mul2 ? mul_const[63:32] : mul_const[31:0];
  assign prod   = {32'd0, mul_a} * {32'd0, mul_b};
  assign hi_sum = acc[63:32] + prod[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      hash <= '0;
    end else if (cmd.ld_start) begin
      hash <= FNV_BASIS ^ item.word;
    end else if (cmd.mul2) begin
      hash <= {hi_sum, acc[31:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_mix) begin
      x <= hash ^ operand;
    end else if (cmd.ld_shift) begin
      x <= shifted;
    end
    if (cmd.mul0) begin
      acc <= prod;
    end else if (cmd.mul1) begin
      acc[63:32] <= hi_sum;
    end
    if (cmd.emit) begin
      result.out_byte <= hash[TOP_LSB +: 8];
      result.last     <= cmd.last;
    end
  end

endmodule

// ----- rtl/core/fnvxs_ctrl.sv -----
module fnvxs_ctrl #(
  parameter int unsigned OUT_BYTES = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  logic [1:0]       item_func,
  output logic             result_valid,
  input  logic             result_ready,
  output fnvxs_pkg::cmd_t  cmd
);
  import fnvxs_pkg::*;

  localparam int unsigned CNT_W = (OUT_BYTES > 1) ? $clog2(OUT_BYTES) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OUT_BYTES - 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL0 = 5'b00010,
    ST_MUL1 = 5'b00100,
    ST_MUL2 = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  state_t           state, state_next;
  logic             squeeze, squeeze_next;
  logic [CNT_W-1:0] count, count_next;
  logic             result_valid_next;
  logic             accept;
  logic             slot_free;
  logic             at_last;

  assign item_ready = (state == ST_IDLE);
  assign accept     = item_valid && item_ready;
  assign slot_free  = !result_valid || result_ready;
  assign at_last    = (count == CNT_LAST);

  always_comb begin
    state_next        = state;
    squeeze_next      = squeeze;
    count_next        = count;
    result_valid_next = result_valid && !result_ready;
    cmd               = '0;
    cmd.sel_xs        = squeeze;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (item_func) inside
            FUNC_START: begin
              cmd.ld_start = 1'b1;
            end
            FUNC_LENGTH, FUNC_BYTE: begin
              cmd.ld_mix   = 1'b1;
              cmd.mix_byte = (item_func == FUNC_BYTE);
              squeeze_next = 1'b0;
              state_next   = ST_MUL0;
            end
            default: begin
              cmd.ld_shift = 1'b1;
              squeeze_next = 1'b1;
              count_next   = '0;
              state_next   = ST_MUL0;
            end
          endcase
        end
      end
      ST_MUL0: begin
        cmd.mul0   = 1'b1;
        state_next = ST_MUL1;
      end
      ST_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = squeeze ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        // wait for the result register; next byte's xorshift overlaps the load
        if (slot_free) begin
          cmd.emit          = 1'b1;
          cmd.last          = at_last;
          result_valid_next = 1'b1;
          if (at_last) begin
            state_next = ST_IDLE;
          end else begin
            cmd.ld_shift = 1'b1;
            count_next   = count + 1'b1;
            state_next   = ST_MUL0;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      squeeze      <= 1'b0;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      squeeze      <= squeeze_next;
      count        <= count_next;
      result_valid <= result_valid_next;
    end
  end

  a_squeeze_starts: assert property (@(posedge clk) disable iff (rst)
    accept && item_func == FUNC_SQUEEZE |=> state == ST_MUL0 && count == '0 && squeeze)
    else $error("squeeze transaction did not start the multiply sequence");

  a_mix_returns: assert property (@(posedge clk) disable iff (rst)
    state == ST_MUL2 && !squeeze |=> state == ST_IDLE)
    else $error("absorb did not return to idle after the multiply");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_LAST)
    else $error("byte counter past end of squeeze run");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && cmd.last |=> state == ST_IDLE && result_valid)
    else $error("final byte did not end the squeeze run");

endmodule

// ----- rtl/core/fnv_absorb_xorshift_squeeze.sv -----
// FNV-1a absorb / xorshift64* squeeze engine.
// Input channel item_valid/item_ready/item carries one transaction per item:
// start (load basis ^ domain word), length or byte absorb, or squeeze.
// Output channel result_valid/result_ready/result carries one squeezed byte
// per transaction, with last set on the final byte of a run.
// Length and byte absorbs xor the operand in, then make three passes through
// a single shared 32x32 multiplier that forms the 64-bit product from its
// partial products. A squeeze runs each byte through xorshift, three multiply
// passes and a load into the result register; item_ready returns once the last
// byte of the run is loaded.
// One item is worked on at a time; item_ready is high only when idle.
// The result register lets the next item be taken while the last byte of a
// run still waits; a stalled receiver holds the engine before the next byte.
// Reset clears the hash state to zero and drops result_valid.
module fnv_absorb_xorshift_squeeze #(
  parameter int unsigned OUT_BYTES = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  fnvxs_pkg::in_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output fnvxs_pkg::out_t  result
);
  import fnvxs_pkg::*;

  cmd_t cmd;

  fnvxs_ctrl #(
    .OUT_BYTES(OUT_BYTES)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item_func    (item.func),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .cmd          (cmd)
  );

  fnvxs_dpath u_dpath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .item   (item),
    .result (result)
  );

endmodule

// ----- tb/fnv_absorb_xorshift_squeeze_test.sv -----
module fnv_absorb_xorshift_squeeze_test;
  import fnvxs_pkg::*;

  localparam int unsigned OUT_BYTES  = 32;
  localparam int unsigned DRAIN_WAIT = 4 * OUT_BYTES + 16;
  localparam int unsigned CYCLE_MAX  = 600000;
  localparam int unsigned ITEMS_PER_PHASE = 50;

  logic clk;
  logic rst;
  logic item_valid;
  logic item_ready;
  in_t  item;
  logic result_valid;
  logic result_ready;
  out_t result;

  fnv_absorb_xorshift_squeeze #(
    .OUT_BYTES(OUT_BYTES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  in_t         pending_items[$];
  out_t        expected_bytes[$];
  logic [63:0] model_hash;
  logic        item_taken;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned cycle_cnt;
  int unsigned mismatches;
  int unsigned items_accepted;
  int unsigned squeezes_accepted;
  int unsigned bytes_checked;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic in_t mk_item(logic [1:0] f, logic [63:0] w, logic [7:0] b);
    in_t it;
    it.func      = f;
    it.word      = w;
    it.data_byte = b;
    return it;
  endfunction

  function automatic logic [63:0] xorshift_star(logic [63:0] s);
    logic [63:0] x;
    x = s ^ (s >> XS_SHR_A);
    x = x ^ (x << XS_SHL);
    x = x ^ (x >> XS_SHR_B);
    return x * XS_MULT;
  endfunction

  // Advance the hash model by one accepted item, queueing any squeezed bytes
  function automatic void hash_model_step(in_t it);
    out_t b;
    case (it.func)
      FUNC_START: begin
        model_hash = FNV_BASIS ^ it.word;
      end
      FUNC_LENGTH: begin
        model_hash = (model_hash ^ it.word) * FNV_PRIME;
      end
      FUNC_BYTE: begin
        model_hash = (model_hash ^ {56'd0, it.data_byte}) * FNV_PRIME;
      end
      default: begin
        for (int k = 0; k < OUT_BYTES; k++) begin
          model_hash = xorshift_star(model_hash);
          b.out_byte = model_hash[TOP_LSB +: 8];
          b.last     = (k == OUT_BYTES - 1);
          expected_bytes.push_back(b);
        end
        squeezes_accepted++;
      end
    endcase
  endfunction

  function automatic void note_mismatch(string what, int unsigned exp_v, int unsigned got_v);
    if (mismatches < 10)
      $display("mismatch on byte %0d: %s expected %0h got %0h",
               bytes_checked, what, exp_v, got_v);
    mismatches++;
  endfunction

  // driver: inputs move on the falling edge only
  always @(negedge clk) begin
    if (!rst) begin
      result_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (!item_valid || item_taken) begin
        item_taken <= 1'b0;
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          item       <= pending_items.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: both channels sampled on the rising edge
  always @(posedge clk) begin : monitor
    out_t want;
    cycle_cnt <= cycle_cnt + 1;
    if (!rst && item_valid && item_ready) begin
      hash_model_step(item);
      items_accepted++;
      item_taken <= 1'b1;
    end
    if (!rst && result_valid && result_ready) begin
      if (expected_bytes.size() == 0) begin
        note_mismatch("unexpected transaction, out_byte", 0, result.out_byte);
      end else begin
        want = expected_bytes.pop_front();
        if (result.out_byte !== want.out_byte)
          note_mismatch("out_byte", want.out_byte, result.out_byte);
        if (result.last !== want.last)
          note_mismatch("last", want.last, result.last);
      end
      bytes_checked++;
    end
    if (cycle_cnt > CYCLE_MAX) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned send_pct[4];
    int unsigned recv_pct[4];
    int unsigned pushed;
    int unsigned n;
    int unsigned r;
    logic [63:0] w;

    send_pct = '{0, 48, 0, 32};
    recv_pct = '{0, 0, 48, 32};
    clk               = 1'b0;
    rst               = 1'b1;
    item_valid        = 1'b0;
    item              = '0;
    result_ready      = 1'b0;
    item_taken        = 1'b0;
    model_hash        = '0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    cycle_cnt         = 0;
    mismatches        = 0;
    items_accepted    = 0;
    squeezes_accepted = 0;
    bytes_checked     = 0;

    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // squeeze and absorb straight out of reset, no start
    pending_items.push_back(mk_item(FUNC_SQUEEZE, '1, 8'hFF));
    pending_items.push_back(mk_item(FUNC_BYTE, '1, 8'hFF));
    pending_items.push_back(mk_item(FUNC_SQUEEZE, '0, 8'h00));
    // field extremes; unused fields carry junk
    pending_items.push_back(mk_item(FUNC_START, '0, 8'hFF));
    pending_items.push_back(mk_item(FUNC_LENGTH, '0, 8'hFF));
    pending_items.push_back(mk_item(FUNC_BYTE, '1, 8'h00));
    pending_items.push_back(mk_item(FUNC_SQUEEZE, '0, 8'h00));
    pending_items.push_back(mk_item(FUNC_START, '1, 8'h00));
    pending_items.push_back(mk_item(FUNC_LENGTH, '1, 8'h00));
    pending_items.push_back(mk_item(FUNC_BYTE, '0, 8'hFF));
    pending_items.push_back(mk_item(FUNC_BYTE, '0, 8'hA5));
    // back-to-back squeezes carry on from the previous state
    pending_items.push_back(mk_item(FUNC_SQUEEZE, '0, 8'h00));
    pending_items.push_back(mk_item(FUNC_SQUEEZE, '1, 8'hFF));
    // byte count short of the length, then one over
    pending_items.push_back(mk_item(FUNC_START, 64'h5555_5555_5555_5555, 8'h00));
    pending_items.push_back(mk_item(FUNC_LENGTH, 64'd3, 8'h00));
    pending_items.push_back(mk_item(FUNC_BYTE, '0, 8'h5A));
    pending_items.push_back(mk_item(FUNC_SQUEEZE, '0, 8'h00));
    pending_items.push_back(mk_item(FUNC_START, 64'hAAAA_AAAA_AAAA_AAAA, 8'h00));
    pending_items.push_back(mk_item(FUNC_LENGTH, 64'd1, 8'h00));
    pending_items.push_back(mk_item(FUNC_BYTE, '0, 8'h00));
    pending_items.push_back(mk_item(FUNC_BYTE, '0, 8'h7F));
    pending_items.push_back(mk_item(FUNC_SQUEEZE, '0, 8'h00));

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = send_pct[phase];
      recv_stall_pct = recv_pct[phase];
      pushed = 0;
      while (pushed < ITEMS_PER_PHASE) begin
        r = $urandom_range(9);
        if (r < 7) begin
          // well-formed message, occasionally without a start, with a random length word or a wrong byte count
          n = $urandom_range(6);
          if ($urandom_range(9) != 0) begin
            pending_items.push_back(mk_item(FUNC_START, {$urandom, $urandom},
                                            8'($urandom)));
            pushed++;
          end
          w = ($urandom_range(7) == 0) ? {$urandom, $urandom} : 64'(n);
          pending_items.push_back(mk_item(FUNC_LENGTH, w, 8'($urandom)));
          pushed++;
          if ($urandom_range(7) == 0)
            n = $urandom_range(8);
          for (int k = 0; k < n; k++) begin
            pending_items.push_back(mk_item(FUNC_BYTE, {$urandom, $urandom},
                                            8'($urandom_range(255))));
            pushed++;
          end
          pending_items.push_back(mk_item(FUNC_SQUEEZE, {$urandom, $urandom},
                                          8'($urandom)));
          pushed++;
        end else begin
          n = $urandom_range(1, 4);
          for (int k = 0; k < n; k++) begin
            pending_items.push_back(mk_item(2'($urandom_range(3)), {$urandom, $urandom},
                                            8'($urandom)));
            pushed++;
          end
        end
      end
      // sender holds off until every byte of the phase has come back
      do @(negedge clk);
      while (pending_items.size() != 0 || item_valid || expected_bytes.size() != 0);
    end

    recv_stall_pct = 0;
    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_bytes.size() != 0) begin
      $display("%0d squeezed bytes never arrived", expected_bytes.size());
      mismatches++;
    end

    $display("%0d items taken, %0d of them squeezes; %0d result bytes compared",
             items_accepted, squeezes_accepted, bytes_checked);
    $display("phases: free-running, sender gaps, receiver stalls, both; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
